### design/sfs_pkg.sv
// Shared types and constants for the sprite animation frame sequencer.
// No dependencies; every other design file imports this package.
package sfs_pkg;

   localparam int TickW    = 16;
   localparam int TotalW   = 9;
   localparam int ModeW    = 3;
   localparam int FrameW   = 8;
   localparam int ElapsedW = 26;
   localparam int HalfW    = TickW + TotalW;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 16;
   localparam int DivSteps = ElapsedW;
   localparam int DivCntW  = $clog2(DivSteps + 1);

   // register indexes on the write port
   localparam logic [CsrIdxW-1:0] CSR_FRAME_TICKS = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_TOTAL = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_MODE_FLAGS  = 2'd2;

   // mode flag bit positions
   localparam int ModeRepeat   = 0;
   localparam int ModePingPong = 1;
   localparam int ModeReverse  = 2;

   typedef struct packed {
      logic [TickW-1:0] tick_delta;
      logic             restart;
   } req_type;

   typedef struct packed {
      logic [FrameW-1:0] frame_index;
      logic              running;
      logic              end_pulse;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load_in;    // capture the accepted item
      logic prep;       // apply restart, form sum and half length
      logic add;        // commit sum, detect cycle end
      logic div_start;  // launch the shared divider
      logic div_sel;    // 0: wrap modulo, 1: frame index divide
      logic mod_wr;     // write wrapped elapsed time
      logic shown_wr;   // write frame index from quotient
      logic out_load;   // load the result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic active;
      logic at_end;     // sum reached cycle length
      logic repeat_on;
      logic div_done;
   } sts_type;

endpackage

### design/sfs_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on sfs_pkg for operand widths.
module sfs_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sfs_pkg::ElapsedW-1:0] dividend,
   input  logic [sfs_pkg::ElapsedW-1:0] divisor,
   output logic                         done,
   output logic [sfs_pkg::ElapsedW-1:0] quotient,
   output logic [sfs_pkg::ElapsedW-1:0] remainder
);
   import sfs_pkg::*;

   logic [ElapsedW-1:0] quo_ff, quo_in;
   logic [ElapsedW-1:0] rem_ff, rem_in;
   logic [ElapsedW-1:0] dsr_ff, dsr_in;
   logic [DivCntW-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [ElapsedW:0]   rem_sh;
   logic                fits;

   assign rem_sh = {rem_ff, quo_ff[ElapsedW-1]};
   assign fits   = rem_sh >= {1'b0, dsr_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = DivCntW'(DivSteps);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ElapsedW-2:0], fits};
         rem_in = fits ? ElapsedW'(rem_sh - {1'b0, dsr_ff}) : rem_sh[ElapsedW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DivCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### design/sfs_dpath.sv
// Datapath: config registers, animation state, length multiply, index math.
// Depends on sfs_pkg and sfs_div.
module sfs_dpath #(
   parameter int MAX_FRAMES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [sfs_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [sfs_pkg::CsrDataW-1:0] csr_wdata,
   input  sfs_pkg::req_type             req_data,
   input  sfs_pkg::cmd_type             cmd,
   output sfs_pkg::sts_type             sts,
   output sfs_pkg::rsp_type             rsp_data
);
   import sfs_pkg::*;

   // configuration
   logic [TickW-1:0]    ticks_ff;
   logic [TotalW-1:0]   total_ff;
   logic [ModeW-1:0]    mode_ff;
   // animation state
   logic [ElapsedW-1:0] elapsed_ff, elapsed_in;
   logic                active_ff, active_in;
   logic [FrameW-1:0]   shown_ff, shown_in;
   logic                ended_ff, ended_in;
   // per-item working registers
   req_type             item_ff, item_in;
   logic [ElapsedW-1:0] sum_ff, sum_in;
   logic [HalfW-1:0]    half_ff, half_in;
   logic [TickW-1:0]    ft_ff, ft_in;
   logic [TotalW-1:0]   fcm1_ff, fcm1_in;
   rsp_type             out_ff, out_in;

   logic [TickW-1:0]    ft;
   logic [TotalW-1:0]   fc;
   logic [ElapsedW-1:0] base;
   logic [ElapsedW-1:0] len;
   logic [ElapsedW-1:0] t_val;
   logic [ElapsedW-1:0] dvd, dsr, quo, rem;
   logic                div_done;
   logic [TotalW-1:0]   idx_clamp, idx_fin;
   logic                pp;

   assign pp = mode_ff[ModePingPong];
   assign ft = (ticks_ff == '0) ? TickW'(1) : ticks_ff;

   always_comb begin
      fc = (total_ff == '0) ? TotalW'(1) : total_ff;
      if (32'(fc) > MAX_FRAMES) begin
         fc = TotalW'(MAX_FRAMES);
      end
   end

   assign base = item_ff.restart ? '0 : elapsed_ff;
   assign len  = pp ? {half_ff, 1'b0} : {1'b0, half_ff};
   // mirrored time in the return half of a ping-pong cycle
   assign t_val = (pp && ({1'b0, elapsed_ff} >= {2'b0, half_ff})) ? len - elapsed_ff
                                                                 : elapsed_ff;

   assign dvd = cmd.div_sel ? t_val : sum_ff;
   assign dsr = cmd.div_sel ? {{(ElapsedW-TickW){1'b0}}, ft_ff} : len;

   sfs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dvd),
      .divisor   (dsr),
      .done      (div_done),
      .quotient  (quo),
      .remainder (rem)
   );

   always_comb begin
      idx_clamp = (quo > {{(ElapsedW-TotalW){1'b0}}, fcm1_ff}) ? fcm1_ff
                                                                : quo[TotalW-1:0];
      idx_fin   = mode_ff[ModeReverse] ? fcm1_ff - idx_clamp : idx_clamp;
   end

   always_comb begin
      item_in    = item_ff;
      sum_in     = sum_ff;
      half_in    = half_ff;
      ft_in      = ft_ff;
      fcm1_in    = fcm1_ff;
      elapsed_in = elapsed_ff;
      active_in  = active_ff;
      shown_in   = shown_ff;
      ended_in   = ended_ff;
      out_in     = out_ff;
      if (cmd.load_in) begin
         item_in = req_data;
      end
      if (cmd.prep) begin
         if (item_ff.restart) begin
            elapsed_in = '0;
            active_in  = 1'b1;
         end
         sum_in   = ElapsedW'({1'b0, base} + {{(ElapsedW+1-TickW){1'b0}},
                                             item_ff.tick_delta});
         half_in  = HalfW'(ft * fc);
         ft_in    = ft;
         fcm1_in  = fc - 1'b1;
         ended_in = 1'b0;
      end
      if (cmd.add) begin
         elapsed_in = sum_ff;
         if (sum_ff >= len) begin
            ended_in = 1'b1;
            if (!mode_ff[ModeRepeat]) begin
               active_in = 1'b0;
            end
         end
      end
      if (cmd.mod_wr) begin
         elapsed_in = rem;
      end
      if (cmd.shown_wr) begin
         shown_in = idx_fin[FrameW-1:0];
      end
      if (cmd.out_load) begin
         out_in.frame_index = shown_ff;
         out_in.running     = active_ff;
         out_in.end_pulse   = ended_ff;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      sum_ff  <= sum_in;
      half_ff <= half_in;
      ft_ff   <= ft_in;
      fcm1_ff <= fcm1_in;
      out_ff  <= out_in;
      if (reset) begin
         ticks_ff   <= TickW'(1);
         total_ff   <= TotalW'(1);
         mode_ff    <= '0;
         elapsed_ff <= '0;
         active_ff  <= 1'b0;
         shown_ff   <= '0;
         ended_ff   <= 1'b0;
      end else begin
         elapsed_ff <= elapsed_in;
         active_ff  <= active_in;
         shown_ff   <= shown_in;
         ended_ff   <= ended_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FRAME_TICKS: ticks_ff <= csr_wdata[TickW-1:0];
               CSR_FRAME_TOTAL: total_ff <= csr_wdata[TotalW-1:0];
               CSR_MODE_FLAGS:  mode_ff  <= csr_wdata[ModeW-1:0];
               default: ;
            endcase
         end
      end
   end

   assign sts.active    = active_ff;
   assign sts.at_end    = sum_ff >= len;
   assign sts.repeat_on = mode_ff[ModeRepeat];
   assign sts.div_done  = div_done;
   assign rsp_data      = out_ff;

endmodule

### design/sfs_ctrl.sv
// Sequencing controller: steps one item through the datapath.
// Depends on sfs_pkg for command and status structs.
module sfs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  sfs_pkg::sts_type sts,
   output sfs_pkg::cmd_type cmd
);
   import sfs_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_ADD, ST_MOD, ST_IDX, ST_DIV, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (!sts.active) begin
               state_in = ST_FINISH;
            end else begin
               cmd.add = 1'b1;
               if (sts.at_end && sts.repeat_on) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_MOD;
               end else if (sts.at_end) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_IDX;
               end
            end
         end
         ST_MOD: begin
            if (sts.div_done) begin
               cmd.mod_wr = 1'b1;
               state_in   = ST_IDX;
            end
         end
         ST_IDX: begin
            cmd.div_sel   = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_sel = 1'b1;
            if (sts.div_done) begin
               cmd.shown_wr = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/sprite_animation_frame_sequencer.sv
// Sprite animation frame sequencer, top level: controller plus datapath. Depends on sfs_pkg.
// The shared 26-step divider runs once for the frame index and once more for the
// repeat wrap; it is skipped when the animation is stopped or ends without repeat.
// A new item is taken only once the previous one is through; an unaccepted result
// delays the next.
// Reset (sync, active high): time, frame, active cleared; ticks and count 1, mode 0.
module sprite_animation_frame_sequencer #(
   parameter int MAX_FRAMES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   // input item channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  sfs_pkg::req_type             req_data,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output sfs_pkg::rsp_type             rsp_data,
   // register write port
   input  logic                         csr_we,
   input  logic [sfs_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [sfs_pkg::CsrDataW-1:0] csr_wdata
);
   import sfs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Controller walks each item: prep (restart, length multiply), add and end
   // check, optional modulo wrap, frame divide if still running, result load.
   // A new input transfer is taken while the previous result still waits.
   sfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath holds registers, elapsed time, active flag and shown frame.
   sfs_dpath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
